FILE: rtl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants of the best-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

	localparam int GRANULE_BYTES    = 32;
	localparam int CACHE_ALIGN_SIZE = 32;

	// result status codes
	localparam logic [1:0] RES_OK           = 2'd0;
	localparam logic [1:0] RES_ALLOC_FAIL   = 2'd1;
	localparam logic [1:0] RES_FREE_IGNORED = 2'd2;
	localparam logic [1:0] RES_CORRUPT      = 2'd3;

	// header status word values
	localparam logic [31:0] HS_FREE    = 32'd0;
	localparam logic [31:0] HS_USED    = 32'd1;
	localparam logic [31:0] HS_ALIGNED = 32'd2;

	// configuration register indexes
	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_BYTES = 1'b1;

	// word offset inside a chunk header
	typedef enum logic [1:0] {
		OFS_STATUS = 2'd0,
		OFS_SIZE   = 2'd1,
		OFS_PREV   = 2'd2,
		OFS_NEXT   = 2'd3
	} ofs_t;

	// which write sequence is running
	typedef enum logic [1:0] {
		WK_RB    = 2'd0,
		WK_ALLOC = 2'd1,
		WK_FREE  = 2'd2
	} wk_t;

	typedef struct packed {
		logic        func;
		logic [16:0] req_bytes;
		logic [16:0] align_bytes;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] block_addr;
		logic [1:0]  status;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bfha_if.sv
// ----------------------------------------------------------------------------
// bfha_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfha_req_if;
	logic             valid;
	logic             ready;
	bfha_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bfha_rsp_if;
	logic             valid;
	logic             ready;
	bfha_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/best_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// Best-fit allocator over an in-band heap with an address-ordered free list.
// ----------------------------------------------------------------------------
// The whole heap, headers included, sits in one single-port RAM of
// HEAP_BYTES/4 words; every header read or write is one RAM access, so the
// cost of a request grows with the free-list nodes visited (allocate) or
// passed (free). The walk length is set by the list, so latency varies per
// request. One request is in flight at a time; the response sits in an output
// register so a new request is taken while it waits. After reset or any
// register write the heap is rebuilt as one free chunk, during which no
// request is taken. Headers outside the heap read as zero and writes to them
// are dropped.
`default_nettype none

module best_fit_heap_allocator_top #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	bfha_req_if.sink         req,
	bfha_rsp_if.source       rsp
);

	localparam int WORDS = HEAP_BYTES / 4;
	localparam int IW    = $clog2(WORDS);
	localparam int SPW   = $clog2(HEAP_BYTES + 1);
	localparam int WCW   = SPW + 2;
	localparam logic [31:0] HDR = 32'(HEADER_BYTES);

	typedef enum logic [29:0] {
		S_IDLE   = 30'd1 << 0,
		S_RINIT  = 30'd1 << 1,
		S_WR     = 30'd1 << 2,
		S_DONE   = 30'd1 << 3,
		S_ASTART = 30'd1 << 4,
		S_AWALK  = 30'd1 << 5,
		S_ASZ    = 30'd1 << 6,
		S_ANX    = 30'd1 << 7,
		S_APICK  = 30'd1 << 8,
		S_ABP    = 30'd1 << 9,
		S_ABN    = 30'd1 << 10,
		S_FSTART = 30'd1 << 11,
		S_FSTRD  = 30'd1 << 12,
		S_FST    = 30'd1 << 13,
		S_FOWN   = 30'd1 << 14,
		S_FLIST  = 30'd1 << 15,
		S_FWALK  = 30'd1 << 16,
		S_FNX    = 30'd1 << 17,
		S_FPOS   = 30'd1 << 18,
		S_FNN    = 30'd1 << 19,
		S_MSTART = 30'd1 << 20,
		S_MSZ    = 30'd1 << 21,
		S_MNX    = 30'd1 << 22,
		S_MNNRD  = 30'd1 << 23,
		S_MNN    = 30'd1 << 24,
		S_MW2    = 30'd1 << 25,
		S_MRS    = 30'd1 << 26,
		S_MW3    = 30'd1 << 27,
		S_MEND   = 30'd1 << 28,
		S_MPV    = 30'd1 << 29
	} state_t;

	state_t            state_q;
	logic [31:0]       base_q;
	logic [16:0]       bytes_q;
	logic [31:0]       org_q;
	logic [SPW-1:0]    span_q;
	logic [31:0]       free_head_q;
	bfha_pkg::req_t    req_q;
	bfha_pkg::wk_t     wk_q;
	logic [3:0]        wstep_q;
	logic [WCW-1:0]    wc_q;
	logic [31:0]       cur_q;
	logic [31:0]       best_q;
	logic [31:0]       bsz_q;
	logic [16:0]       bpad_q;
	logic [17:0]       size_q;
	logic [31:0]       want_q;
	logic              split_q;
	logic [31:0]       bprev_q;
	logic [31:0]       bnext_q;
	logic [31:0]       follow_q;
	logic [31:0]       chunk_q;
	logic              owned_q;
	logic [31:0]       nx_q;
	logic [31:0]       nn_q;
	logic              after_q;
	logic [31:0]       mc_q;
	logic [31:0]       msz_q;
	logic [31:0]       mnx_q;
	logic [31:0]       mnn_q;
	logic              second_q;
	logic [31:0]       res_addr_q;
	logic [1:0]        res_st_q;
	logic              ov_q;
	bfha_pkg::rsp_t    out_q;
	logic              rd_ok_q;

	// memory access of the current cycle
	logic              m_we;
	logic [31:0]       m_base;
	bfha_pkg::ofs_t    m_ofs;
	logic [31:0]       m_wdata;
	logic [31:0]       m_a;
	logic [31:0]       m_off;
	logic              m_valid;
	logic [31:0]       ram_rdata;
	logic [31:0]       rdm;

	// write sequence entry
	logic              wl_en;
	logic [31:0]       wl_base;
	bfha_pkg::ofs_t    wl_ofs;
	logic [31:0]       wl_data;
	logic              wl_last;

	// datapath
	logic [31:0]       org_d;
	logic [32:0]       room_d;
	logic [32:0]       span_w;
	logic [SPW-1:0]    span_d;
	logic [16:0]       align_m;
	logic [17:0]       size_d;
	logic              bad_alloc;
	logic [16:0]       pad_tmp;
	logic [16:0]       pad_cur;
	logic              fits;
	logic [31:0]       want_d;
	logic [31:0]       follow_d;
	logic [31:0]       body;
	logic [WCW-1:0]    wc_n;
	logic [WCW-1:0]    wlim;
	logic [32:0]       f_lo;
	logic [32:0]       f_hi;
	logic              bad_free;
	logic              after_d;
	logic [31:0]       nn_d;
	logic              out_load;

	function automatic logic in_heap(input logic [31:0] a);
		in_heap = (a >= org_q) && ((a - org_q) < {{(32-SPW){1'b0}}, span_q});
	endfunction

	function automatic logic link_ok(input logic [31:0] a);
		link_ok = (a == 32'd0) || in_heap(a);
	endfunction

	// ---------------- datapath ----------------
	always_comb begin
		org_d = base_q & ~32'(bfha_pkg::CACHE_ALIGN_SIZE - 1);
		if (org_d == 32'd0) begin
			org_d = 32'(bfha_pkg::GRANULE_BYTES);
		end
		room_d = 33'h1_0000_0000 - {1'b0, org_d};
		span_w = {16'd0, bytes_q};
		if (span_w > 33'(HEAP_BYTES)) begin
			span_w = 33'(HEAP_BYTES);
		end
		if (span_w > room_d) begin
			span_w = room_d;
		end
		span_d = span_w[SPW-1:0];
	end

	assign align_m   = req_q.align_bytes - 17'd1;
	assign size_d    = ({1'b0, req_q.req_bytes} + 18'(bfha_pkg::GRANULE_BYTES - 1))
	                   & ~18'(bfha_pkg::GRANULE_BYTES - 1);
	assign bad_alloc = (req_q.req_bytes == 17'd0) || (req_q.align_bytes == 17'd0)
	                   || ((req_q.align_bytes & align_m) != 17'd0);
	assign pad_tmp   = cur_q[16:0] + HDR[16:0];
	assign pad_cur   = (req_q.align_bytes - (pad_tmp & align_m)) & align_m;
	assign fits      = rdm >= ({14'd0, size_q} + {15'd0, pad_cur});
	assign want_d    = {14'd0, size_q} + {15'd0, bpad_q} + HDR;
	assign follow_d  = split_q ? (best_q + want_q) : rdm;
	assign body      = best_q + {15'd0, bpad_q} + HDR;
	assign wc_n      = wc_q + WCW'(HEADER_BYTES);
	// list too long once the node count exceeds span / header + 2
	assign wlim      = {2'b00, span_q} + WCW'(2 * HEADER_BYTES);
	assign f_lo      = {1'b0, org_q} + {1'b0, HDR};
	assign f_hi      = {1'b0, org_q} + {{(33-SPW){1'b0}}, span_q};
	assign bad_free  = ({1'b0, req_q.free_addr} < f_lo) || ({1'b0, req_q.free_addr} > f_hi);
	assign after_d   = (cur_q != 32'd0) && (chunk_q > cur_q);
	assign nn_d      = after_d ? nx_q : free_head_q;

	// ---------------- write sequences ----------------
	always_comb begin
		wl_en   = 1'b0;
		wl_base = 32'd0;
		wl_ofs  = bfha_pkg::OFS_STATUS;
		wl_data = 32'd0;
		wl_last = 1'b0;
		case (wk_q)
			bfha_pkg::WK_RB: begin
				wl_en   = 1'b1;
				wl_base = org_q;
				wl_last = (wstep_q == 4'd3);
				case (wstep_q)
					4'd0: wl_data = bfha_pkg::HS_FREE;
					4'd1: begin
						wl_ofs  = bfha_pkg::OFS_SIZE;
						wl_data = {{(32-SPW){1'b0}}, span_q} - HDR;
					end
					4'd2: wl_ofs = bfha_pkg::OFS_PREV;
					4'd3: wl_ofs = bfha_pkg::OFS_NEXT;
					default: wl_en = 1'b0;
				endcase
			end
			bfha_pkg::WK_ALLOC: begin
				wl_last = (wstep_q == 4'd11);
				case (wstep_q)
					4'd0: begin
						wl_en = split_q; wl_base = follow_q; wl_data = bfha_pkg::HS_FREE;
					end
					4'd1: begin
						wl_en = split_q; wl_base = follow_q;
						wl_ofs = bfha_pkg::OFS_SIZE; wl_data = bsz_q - want_q;
					end
					4'd2: begin
						wl_en = split_q; wl_base = follow_q;
						wl_ofs = bfha_pkg::OFS_NEXT; wl_data = bnext_q;
					end
					4'd3: begin
						wl_en = split_q && (bnext_q != 32'd0); wl_base = bnext_q;
						wl_ofs = bfha_pkg::OFS_PREV; wl_data = follow_q;
					end
					4'd4: begin
						wl_en = split_q; wl_base = best_q;
						wl_ofs = bfha_pkg::OFS_SIZE; wl_data = {14'd0, size_q} + {15'd0, bpad_q};
					end
					4'd5: begin
						wl_en = 1'b1; wl_base = best_q; wl_data = bfha_pkg::HS_USED;
					end
					4'd6: begin
						wl_en = (bprev_q != 32'd0); wl_base = bprev_q;
						wl_ofs = bfha_pkg::OFS_NEXT; wl_data = follow_q;
					end
					4'd7: begin
						wl_en = (follow_q != 32'd0); wl_base = follow_q;
						wl_ofs = bfha_pkg::OFS_PREV; wl_data = bprev_q;
					end
					4'd8: begin
						wl_en = 1'b1; wl_base = best_q; wl_ofs = bfha_pkg::OFS_PREV;
					end
					4'd9: begin
						wl_en = 1'b1; wl_base = best_q; wl_ofs = bfha_pkg::OFS_NEXT;
					end
					// aligned marker just below the body
					4'd10: begin
						wl_en = (bpad_q != 17'd0); wl_base = body - HDR;
						wl_data = bfha_pkg::HS_ALIGNED;
					end
					4'd11: begin
						wl_en = (bpad_q != 17'd0); wl_base = body - HDR;
						wl_ofs = bfha_pkg::OFS_PREV; wl_data = best_q;
					end
					default: wl_en = 1'b0;
				endcase
			end
			bfha_pkg::WK_FREE: begin
				wl_last = (wstep_q == 4'd4);
				case (wstep_q)
					4'd0: begin
						wl_en = 1'b1; wl_base = chunk_q; wl_data = bfha_pkg::HS_FREE;
					end
					4'd1: begin
						wl_en = 1'b1; wl_base = chunk_q;
						wl_ofs  = after_q ? bfha_pkg::OFS_PREV : bfha_pkg::OFS_NEXT;
						wl_data = after_q ? cur_q : nn_q;
					end
					4'd2: begin
						wl_en = 1'b1; wl_base = chunk_q;
						wl_ofs  = after_q ? bfha_pkg::OFS_NEXT : bfha_pkg::OFS_PREV;
						wl_data = after_q ? nn_q : 32'd0;
					end
					4'd3: begin
						wl_en = after_q; wl_base = cur_q;
						wl_ofs = bfha_pkg::OFS_NEXT; wl_data = chunk_q;
					end
					4'd4: begin
						wl_en = (nn_q != 32'd0); wl_base = nn_q;
						wl_ofs = bfha_pkg::OFS_PREV; wl_data = chunk_q;
					end
					default: wl_en = 1'b0;
				endcase
			end
			default: wl_en = 1'b0;
		endcase
	end

	// ---------------- memory access ----------------
	always_comb begin
		m_we    = 1'b0;
		m_base  = 32'd0;
		m_ofs   = bfha_pkg::OFS_STATUS;
		m_wdata = 32'd0;
		unique case (state_q)
			S_AWALK: begin m_base = cur_q;   m_ofs = bfha_pkg::OFS_SIZE; end
			S_ASZ:   begin m_base = cur_q;   m_ofs = bfha_pkg::OFS_NEXT; end
			S_APICK: begin m_base = best_q;  m_ofs = bfha_pkg::OFS_PREV; end
			S_ABP:   begin m_base = best_q;  m_ofs = bfha_pkg::OFS_NEXT; end
			S_FSTRD: begin m_base = chunk_q; m_ofs = bfha_pkg::OFS_STATUS; end
			S_FST:   begin m_base = chunk_q; m_ofs = bfha_pkg::OFS_PREV; end
			S_FWALK: begin m_base = cur_q;   m_ofs = bfha_pkg::OFS_NEXT; end
			S_FPOS:  begin m_base = nn_d;    m_ofs = bfha_pkg::OFS_NEXT; end
			S_MSTART: begin m_base = mc_q;   m_ofs = bfha_pkg::OFS_SIZE; end
			S_MSZ:   begin m_base = mc_q;    m_ofs = bfha_pkg::OFS_NEXT; end
			S_MNNRD: begin m_base = mnx_q;   m_ofs = bfha_pkg::OFS_NEXT; end
			S_MNN: begin
				m_we = 1'b1; m_base = mc_q; m_ofs = bfha_pkg::OFS_NEXT; m_wdata = rdm;
			end
			S_MW2: begin
				m_we = (mnn_q != 32'd0); m_base = mnn_q;
				m_ofs = bfha_pkg::OFS_PREV; m_wdata = mc_q;
			end
			S_MRS:   begin m_base = mnx_q;   m_ofs = bfha_pkg::OFS_SIZE; end
			S_MW3: begin
				m_we = 1'b1; m_base = mc_q; m_ofs = bfha_pkg::OFS_SIZE;
				m_wdata = msz_q + rdm + HDR;
			end
			S_MEND:  begin m_base = chunk_q; m_ofs = bfha_pkg::OFS_PREV; end
			S_WR: begin
				m_we = wl_en; m_base = wl_base; m_ofs = wl_ofs; m_wdata = wl_data;
			end
			default: m_we = 1'b0;
		endcase
	end

	assign m_a     = m_base + {28'd0, m_ofs, 2'b00};
	assign m_off   = m_a - org_q;
	assign m_valid = (m_a >= org_q) && (m_off < {{(32-SPW){1'b0}}, span_q});
	// words outside the heap read as zero
	assign rdm     = rd_ok_q ? ram_rdata : 32'd0;

	bfha_ram #(
		.WIDTH (32),
		.DEPTH (WORDS)
	) u_heap (
		.clk   (clk),
		.we    (m_we && m_valid),
		.addr  (m_off[IW+1:2]),
		.wdata (m_wdata),
		.rdata (ram_rdata)
	);

	// ---------------- control ----------------
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.data  = out_q;
	assign out_load  = (state_q == S_DONE) && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RINIT;
			base_q      <= 32'd4096;
			bytes_q     <= 17'd65536;
			org_q       <= 32'd0;
			span_q      <= '0;
			free_head_q <= 32'd0;
			wk_q        <= bfha_pkg::WK_RB;
			wstep_q     <= 4'd0;
			ov_q        <= 1'b0;
			rd_ok_q     <= 1'b0;
			owned_q     <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			rd_ok_q <= m_valid;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q      <= req.data;
						res_addr_q <= 32'd0;
						state_q    <= req.data.func ? S_FSTART : S_ASTART;
					end
				end
				S_RINIT: begin
					org_q   <= org_d;
					span_q  <= span_d;
					wk_q    <= bfha_pkg::WK_RB;
					wstep_q <= 4'd0;
					if ({{(32-SPW){1'b0}}, span_d} >= HDR) begin
						free_head_q <= org_d;
						state_q     <= S_WR;
					end else begin
						free_head_q <= 32'd0;
						state_q     <= S_IDLE;
					end
				end
				S_ASTART: begin
					best_q <= 32'd0;
					bsz_q  <= 32'd0;
					bpad_q <= 17'd0;
					cur_q  <= free_head_q;
					wc_q   <= '0;
					size_q <= size_d;
					if (bad_alloc) begin
						res_st_q <= bfha_pkg::RES_ALLOC_FAIL;
						state_q  <= S_DONE;
					end else if (!link_ok(free_head_q)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_AWALK;
					end
				end
				S_AWALK: begin
					state_q <= (cur_q == 32'd0) ? S_APICK : S_ASZ;
				end
				S_ASZ: begin
					wc_q <= wc_n;
					if (wc_n > wlim) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else if (pad_cur == 17'd0 && rdm == {14'd0, size_q}) begin
						// exact aligned fit ends the walk
						best_q  <= cur_q;
						bsz_q   <= rdm;
						bpad_q  <= 17'd0;
						state_q <= S_APICK;
					end else begin
						if (fits && (best_q == 32'd0 || rdm < bsz_q)) begin
							best_q <= cur_q;
							bsz_q  <= rdm;
							bpad_q <= pad_cur;
						end
						state_q <= S_ANX;
					end
				end
				S_ANX: begin
					if (!link_ok(rdm)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						cur_q   <= rdm;
						state_q <= S_AWALK;
					end
				end
				S_APICK: begin
					if (best_q == 32'd0) begin
						res_st_q <= bfha_pkg::RES_ALLOC_FAIL;
						state_q  <= S_DONE;
					end else begin
						want_q  <= want_d;
						split_q <= bsz_q > want_d;
						state_q <= S_ABP;
					end
				end
				S_ABP: begin
					bprev_q <= rdm;
					state_q <= S_ABN;
				end
				S_ABN: begin
					bnext_q  <= rdm;
					follow_q <= follow_d;
					wk_q     <= bfha_pkg::WK_ALLOC;
					wstep_q  <= 4'd0;
					if (!link_ok(bprev_q) || !link_ok(rdm) || !link_ok(follow_d)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					wstep_q <= wstep_q + 4'd1;
					if (wk_q == bfha_pkg::WK_ALLOC && wstep_q == 4'd6 && bprev_q == 32'd0) begin
						free_head_q <= follow_q;
					end
					if (wk_q == bfha_pkg::WK_FREE && wstep_q == 4'd2 && !after_q) begin
						free_head_q <= chunk_q;
					end
					if (wl_last) begin
						case (wk_q)
							bfha_pkg::WK_ALLOC: begin
								res_st_q   <= bfha_pkg::RES_OK;
								res_addr_q <= body;
								state_q    <= S_DONE;
							end
							bfha_pkg::WK_FREE: begin
								mc_q     <= chunk_q;
								second_q <= 1'b0;
								state_q  <= S_MSTART;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FSTART: begin
					owned_q <= 1'b0;
					chunk_q <= req_q.free_addr - HDR;
					if (bad_free) begin
						res_st_q <= bfha_pkg::RES_FREE_IGNORED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FSTRD;
					end
				end
				S_FSTRD: state_q <= S_FST;
				S_FST: begin
					if (!owned_q && rdm == bfha_pkg::HS_ALIGNED) begin
						state_q <= S_FOWN;
					end else if (rdm != bfha_pkg::HS_USED) begin
						res_st_q <= bfha_pkg::RES_FREE_IGNORED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FLIST;
					end
				end
				S_FOWN: begin
					if (!in_heap(rdm)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						chunk_q <= rdm;
						owned_q <= 1'b1;
						state_q <= S_FSTRD;
					end
				end
				S_FLIST: begin
					cur_q <= free_head_q;
					wc_q  <= '0;
					if (!link_ok(free_head_q)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FWALK;
					end
				end
				S_FWALK: begin
					state_q <= (cur_q == 32'd0) ? S_FPOS : S_FNX;
				end
				S_FNX: begin
					nx_q <= rdm;
					wc_q <= wc_n;
					if (wc_n > wlim || !link_ok(rdm)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else if (rdm == 32'd0 || rdm > chunk_q) begin
						state_q <= S_FPOS;
					end else begin
						cur_q   <= rdm;
						state_q <= S_FWALK;
					end
				end
				S_FPOS: begin
					after_q <= after_d;
					nn_q    <= nn_d;
					wk_q    <= bfha_pkg::WK_FREE;
					wstep_q <= 4'd0;
					state_q <= (nn_d != 32'd0) ? S_FNN : S_WR;
				end
				S_FNN: begin
					if (!link_ok(rdm)) begin
						res_st_q <= bfha_pkg::RES_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_WR;
					end
				end
				S_MSTART: state_q <= (mc_q == 32'd0) ? S_MEND : S_MSZ;
				S_MSZ: begin
					msz_q   <= rdm;
					state_q <= S_MNX;
				end
				S_MNX: begin
					mnx_q <= rdm;
					if (rdm == 32'd0 || rdm != mc_q + msz_q + HDR) begin
						state_q <= S_MEND;
					end else begin
						state_q <= S_MNNRD;
					end
				end
				S_MNNRD: state_q <= S_MNN;
				S_MNN: begin
					mnn_q   <= rdm;
					state_q <= S_MW2;
				end
				S_MW2: state_q <= S_MRS;
				S_MRS: state_q <= S_MW3;
				S_MW3: state_q <= S_MEND;
				S_MEND: begin
					if (second_q) begin
						res_st_q <= bfha_pkg::RES_OK;
						state_q  <= S_DONE;
					end else begin
						second_q <= 1'b1;
						state_q  <= S_MPV;
					end
				end
				// second merge runs on the new previous neighbor
				S_MPV: begin
					mc_q    <= rdm;
					state_q <= S_MSTART;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				ov_q  <= 1'b1;
				out_q <= '{block_addr: res_addr_q, status: res_st_q};
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					bfha_pkg::CFG_HEAP_BASE:  base_q  <= cfg_data;
					bfha_pkg::CFG_HEAP_BYTES: bytes_q <= cfg_data[16:0];
					default: base_q <= base_q;
				endcase
				state_q <= S_RINIT;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfha_ram.sv
// ----------------------------------------------------------------------------
// bfha_ram
// Single-address synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire
